// File: hw/rtl/eirm_pkg.sv
`timescale 1ns / 1ps
// Package for the event interval rate meter: widths, command codes, sequencer
// states and the divider control/status structs. No dependencies.
package eirm_pkg;

  localparam int TIME_W       = 63;
  localparam int PERIOD_W     = 12;
  localparam int US_W         = 20;
  localparam int LIMIT_W      = PERIOD_W + US_W;
  localparam int RING_DEPTH_D = 10;

  localparam logic [US_W-1:0]     US_PER_S       = US_W'(1000000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(1);
  localparam logic [TIME_W-1:0]   MEAN_SENTINEL  = {TIME_W{1'b1}};

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_CHECK,
    ST_READ_NEW,
    ST_READ_OLD,
    ST_SPAN,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/eirm_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: 63-bit dividend by a narrow divisor, one
// quotient bit per cycle. Depends on eirm_pkg.
module eirm_div #(
  parameter int DEN_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  eirm_pkg::div_ctrl_t       ctrl,
  input  logic [eirm_pkg::TIME_W-1:0] dividend,
  input  logic [DEN_W-1:0]          divisor,
  output eirm_pkg::div_status_t     status,
  output logic [eirm_pkg::TIME_W-1:0] quotient
);

  localparam int CNT_W = $clog2(eirm_pkg::TIME_W + 1);

  logic [eirm_pkg::TIME_W-1:0] quo;
  logic [DEN_W-1:0]            rem;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;
  logic [DEN_W:0]              trial;
  logic                        fits;
  logic [DEN_W:0]              diff;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quo[eirm_pkg::TIME_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(eirm_pkg::TIME_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[eirm_pkg::TIME_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// File: hw/rtl/event_interval_rate_meter.sv
`timescale 1ns / 1ps
// Event interval rate meter, top level. Depends on eirm_pkg and eirm_div.
// An event passes through READ_NEW, READ_OLD, SPAN, DIVIDE and DONE; a poll goes
// through ELAPSED and CHECK first. With fewer than two stamps SPAN skips DIVIDE.
// One item at a time: a new item is taken only once its result is loaded into the
// output register; a stalled result holds the block busy. Not ready meanwhile.
// Reset (rst, synchronous): ring empty, slot 0, last report time 0, period 1 s.
module event_interval_rate_meter #(
  parameter int RING_DEPTH = eirm_pkg::RING_DEPTH_D
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [eirm_pkg::TIME_W-1:0]     time_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [eirm_pkg::TIME_W-1:0]     mean_interval_us,
  output logic                            report_due,
  input  logic                            cfg_we,
  input  logic [eirm_pkg::PERIOD_W-1:0]   cfg_wdata
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int EXT_W  = CNT_W + 1;

  // Sequencer and bookkeeping
  eirm_pkg::state_t state, state_next;

  logic [eirm_pkg::PERIOD_W-1:0] period_s;
  logic [SLOT_W-1:0]             write_slot;
  logic [CNT_W-1:0]              stored_count;
  logic [eirm_pkg::TIME_W-1:0]   last_report_time;

  // Per-item working registers
  logic                          cur_cmd;
  logic [eirm_pkg::TIME_W-1:0]   now_us;
  logic [eirm_pkg::TIME_W-1:0]   elapsed;
  logic [eirm_pkg::LIMIT_W-1:0]  limit_us;
  logic [eirm_pkg::TIME_W-1:0]   newest_stamp;
  logic [eirm_pkg::TIME_W-1:0]   mean_res;
  logic                          due_res;

  // Ring memory with a registered read port
  logic [eirm_pkg::TIME_W-1:0]   stamp_ring [RING_DEPTH];
  logic [eirm_pkg::TIME_W-1:0]   rd_data;
  logic [SLOT_W-1:0]             rd_addr;
  logic [SLOT_W-1:0]             newest_slot;
  logic [SLOT_W-1:0]             oldest_slot;
  logic [EXT_W-1:0]              slot_ext;
  logic [EXT_W-1:0]              count_ext;

  // Shared 63-bit subtractor: elapsed time on a poll, ring span later on
  logic [eirm_pkg::TIME_W-1:0]   sub_a;
  logic [eirm_pkg::TIME_W-1:0]   sub_b;
  logic [eirm_pkg::TIME_W-1:0]   sub_y;

  logic                          in_beat;
  logic                          out_load;

  eirm_pkg::div_ctrl_t           div_ctrl;
  eirm_pkg::div_status_t         div_status;
  logic [eirm_pkg::TIME_W-1:0]   div_quotient;

  function automatic eirm_pkg::cmd_t cur_cmd_in();
    return eirm_pkg::cmd_t'(cmd);
  endfunction

  assign in_ready = (state == eirm_pkg::ST_IDLE);
  assign in_beat  = in_valid && in_ready;

  // Newest entry sits just behind the write slot; oldest is count entries back.
  assign newest_slot = (write_slot == '0) ? SLOT_W'(RING_DEPTH - 1)
                                          : write_slot - SLOT_W'(1);
  assign slot_ext    = EXT_W'(write_slot);
  assign count_ext   = EXT_W'(stored_count);
  always_comb begin
    if (slot_ext >= count_ext) begin
      oldest_slot = SLOT_W'(slot_ext - count_ext);
    end else begin
      oldest_slot = SLOT_W'(slot_ext + EXT_W'(RING_DEPTH) - count_ext);
    end
  end

  assign sub_y = sub_a - sub_b;

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      period_s <= eirm_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_s <= cfg_wdata;
    end
  end

  // Ring write on an event beat; read port always registered
  always_ff @(posedge clk) begin
    if (in_beat && (cur_cmd_in() == eirm_pkg::CMD_EVENT)) begin
      stamp_ring[write_slot] <= time_us;
    end
    rd_data <= stamp_ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eirm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, read address, subtractor operands, divider start
  always_comb begin
    state_next     = state;
    rd_addr        = newest_slot;
    sub_a          = now_us;
    sub_b          = last_report_time;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      eirm_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = (cur_cmd_in() == eirm_pkg::CMD_POLL) ? eirm_pkg::ST_ELAPSED
                                                           : eirm_pkg::ST_READ_NEW;
        end
      end
      eirm_pkg::ST_ELAPSED: begin
        state_next = eirm_pkg::ST_CHECK;
      end
      eirm_pkg::ST_CHECK: begin
        state_next = eirm_pkg::ST_READ_NEW;
      end
      eirm_pkg::ST_READ_NEW: begin
        rd_addr    = newest_slot;
        state_next = eirm_pkg::ST_READ_OLD;
      end
      eirm_pkg::ST_READ_OLD: begin
        rd_addr    = oldest_slot;
        state_next = eirm_pkg::ST_SPAN;
      end
      eirm_pkg::ST_SPAN: begin
        sub_a = newest_stamp;
        sub_b = rd_data;
        if (stored_count < CNT_W'(2)) begin
          state_next = eirm_pkg::ST_DONE;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = eirm_pkg::ST_DIVIDE;
        end
      end
      eirm_pkg::ST_DIVIDE: begin
        if (div_status.done) begin
          state_next = eirm_pkg::ST_DONE;
        end
      end
      eirm_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = eirm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = eirm_pkg::ST_IDLE;
      end
    endcase
  end

  // Ring bookkeeping and report period tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot       <= '0;
      stored_count     <= '0;
      last_report_time <= '0;
    end else begin
      if (in_beat && (cur_cmd_in() == eirm_pkg::CMD_EVENT)) begin
        write_slot <= (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                              : write_slot + SLOT_W'(1);
        if (stored_count < CNT_W'(RING_DEPTH)) begin
          stored_count <= stored_count + CNT_W'(1);
        end
      end
      if ((state == eirm_pkg::ST_CHECK) && (elapsed > eirm_pkg::TIME_W'(limit_us))) begin
        last_report_time <= now_us;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_cmd <= cmd;
      now_us  <= time_us;
      due_res <= 1'b0;
    end
    if (state == eirm_pkg::ST_ELAPSED) begin
      elapsed  <= sub_y;
      limit_us <= eirm_pkg::LIMIT_W'(period_s) * eirm_pkg::LIMIT_W'(eirm_pkg::US_PER_S);
    end
    if (state == eirm_pkg::ST_CHECK) begin
      due_res <= (elapsed > eirm_pkg::TIME_W'(limit_us));
    end
    if (state == eirm_pkg::ST_READ_OLD) begin
      newest_stamp <= rd_data;
    end
    if (state == eirm_pkg::ST_SPAN) begin
      mean_res <= eirm_pkg::MEAN_SENTINEL;
    end
    if ((state == eirm_pkg::ST_DIVIDE) && div_status.done) begin
      mean_res <= div_quotient;
    end
  end

  eirm_div #(
    .DEN_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (sub_y),
    .divisor  (stored_count - CNT_W'(1)),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // Output register: drop valid on a taken beat, load a finished result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_interval_us <= mean_res;
      report_due       <= due_res;
    end
  end

  // Checks
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("ready stayed high after an input beat");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(RING_DEPTH))
    else $error("stored count beyond ring depth");

  a_div_active: assert property (@(posedge clk) disable iff (rst)
    (state == eirm_pkg::ST_DIVIDE) |-> (div_status.busy || div_status.done))
    else $error("sequencer waits on an idle divider");

  a_due_only_poll: assert property (@(posedge clk) disable iff (rst)
    (state == eirm_pkg::ST_DONE) && due_res |-> (cur_cmd == eirm_pkg::CMD_POLL))
    else $error("report raised on an event item");

endmodule

// File: bench/tb_event_interval_rate_meter.sv
`timescale 1ns / 1ps
// Self-checking testbench for event_interval_rate_meter: directed table, then
// random phases across several report periods. Depends on eirm_pkg and the RTL.
module tb_event_interval_rate_meter;

  localparam int RING = eirm_pkg::RING_DEPTH_D;
  localparam logic [eirm_pkg::TIME_W-1:0] T_MAX = {eirm_pkg::TIME_W{1'b1}};
  localparam int RANDOM_PHASES = 5;
  localparam int BEATS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES = 80;  // about one item latency of the block

  typedef struct packed {
    logic [eirm_pkg::TIME_W-1:0] mean;
    logic                        due;
  } reading_t;

  // A directed row either writes the report period or sends one input beat.
  typedef enum logic {
    ROW_BEAT,
    ROW_PERIOD
  } row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    eirm_pkg::cmd_t              op;
    logic [eirm_pkg::TIME_W-1:0] value;   // time for a beat, seconds for a period write
    bit                          typed;   // expectation written into the row itself
    reading_t                    want;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  eirm_pkg::cmd_t                cmd;
  logic [eirm_pkg::TIME_W-1:0]   time_us;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [eirm_pkg::TIME_W-1:0]   mean_interval_us;
  logic                          report_due;
  logic                          cfg_we;
  logic [eirm_pkg::PERIOD_W-1:0] cfg_wdata;

  event_interval_rate_meter uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .time_us          (time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mean_interval_us (mean_interval_us),
    .report_due       (report_due),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // Shadow state of the meter, advanced once per accepted input beat.
  logic [eirm_pkg::TIME_W-1:0]   stamps [RING];
  int                            next_slot;
  int                            stamp_count;
  logic [eirm_pkg::TIME_W-1:0]   last_report_us;
  logic [eirm_pkg::PERIOD_W-1:0] period_s;

  reading_t                      awaited_readings[$];
  int                            mismatches;
  int                            calm_beats;
  int                            calm_cycles;
  int                            stall_left;
  logic [eirm_pkg::TIME_W-1:0]   clock_us;   // running time base of the random part
  stim_row_t                     directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the shadow state by one item and return the reading it yields.
  function automatic reading_t meter_reading(input eirm_pkg::cmd_t op,
                                             input logic [eirm_pkg::TIME_W-1:0] t);
    reading_t                    r;
    logic [eirm_pkg::TIME_W-1:0] elapsed;
    logic [eirm_pkg::TIME_W-1:0] span;
    logic [63:0]                 limit_us;
    int                          newest;
    int                          oldest;
    r.due = 1'b0;
    if (op == eirm_pkg::CMD_EVENT) begin
      stamps[next_slot] = t;
      next_slot = (next_slot + 1) % RING;
      if (stamp_count < RING) stamp_count++;
    end else begin
      // Elapsed time wraps like the free-running counter it comes from.
      elapsed  = t - last_report_us;
      limit_us = 64'(period_s) * 64'd1000000;
      if ({1'b0, elapsed} > limit_us) begin
        last_report_us = t;
        r.due = 1'b1;
      end
    end
    if (stamp_count < 2) begin
      r.mean = eirm_pkg::MEAN_SENTINEL;
    end else begin
      newest = (next_slot + RING - 1) % RING;
      oldest = (next_slot + RING - stamp_count) % RING;
      span   = stamps[newest] - stamps[oldest];
      r.mean = span / eirm_pkg::TIME_W'(stamp_count - 1);
    end
    return r;
  endfunction

  function automatic stim_row_t row(input row_kind_t kind, input eirm_pkg::cmd_t op,
                                    input logic [eirm_pkg::TIME_W-1:0] value,
                                    input bit typed,
                                    input logic [eirm_pkg::TIME_W-1:0] mean,
                                    input logic due);
    stim_row_t s;
    s.kind      = kind;
    s.op        = op;
    s.value     = value;
    s.typed     = typed;
    s.want.mean = mean;
    s.want.due  = due;
    return s;
  endfunction

  function automatic logic [eirm_pkg::TIME_W-1:0] rand_time();
    return eirm_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(4, 1);
    return $urandom_range(150, 20);
  endfunction

  // Send one beat; called and returning at a falling edge. Valid stays high
  // on return so back-to-back beats never drop it within one time step.
  task automatic send_beat(input eirm_pkg::cmd_t op,
                           input logic [eirm_pkg::TIME_W-1:0] t,
                           input bit typed, input reading_t want);
    int       gap;
    reading_t predicted;
    if (calm_beats > 0) begin
      calm_beats--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(99, 0) < 2) calm_beats = $urandom_range(80, 30);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = op;
    time_us  = t;
    do @(posedge clk); while (!in_ready);
    predicted = meter_reading(op, t);
    awaited_readings.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Write the period only with the block idle: drain every result first.
  task automatic write_period(input logic [eirm_pkg::PERIOD_W-1:0] seconds);
    in_valid = 1'b0;
    wait (awaited_readings.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = seconds;
    period_s  = seconds;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Random beat: mostly forward time steps, with jumps, backward steps and
  // runs near the top of the counter so the wrap is exercised.
  task automatic send_random_beat();
    int             r;
    eirm_pkg::cmd_t op;
    reading_t       none;
    r = $urandom_range(99, 0);
    if (r < 50)      clock_us = clock_us + eirm_pkg::TIME_W'($urandom_range(3_000_000, 0));
    else if (r < 85) clock_us = clock_us + (rand_time() >> $urandom_range(62, 20));
    else if (r < 91) clock_us = rand_time();
    else if (r < 95) clock_us = clock_us - eirm_pkg::TIME_W'($urandom_range(1000, 1));
    else if (r < 98) clock_us = T_MAX - eirm_pkg::TIME_W'($urandom_range(5_000_000, 0));
    op   = ($urandom_range(99, 0) < 60) ? eirm_pkg::CMD_EVENT : eirm_pkg::CMD_POLL;
    none = '0;
    send_beat(op, clock_us, 1'b0, none);
  endtask

  // Receiver: random stalls, with long stretches of steady ready.
  always @(negedge clk) begin
    int r;
    if (calm_cycles > 0) begin
      calm_cycles--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(99, 0);
      if (r < 2) begin
        calm_cycles = $urandom_range(600, 100);
        out_ready <= 1'b1;
      end else if (r < 20) begin
        stall_left = $urandom_range(3, 1) - 1;
        out_ready <= 1'b0;
      end else if (r < 23) begin
        stall_left = $urandom_range(150, 30) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest awaited reading.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result mean=%0d due=%0b",
                                  mean_interval_us, report_due));
      end else begin
        want = awaited_readings.pop_front();
        if (mean_interval_us !== want.mean)
          report_mismatch($sformatf("mean_interval_us got %0d want %0d",
                                    mean_interval_us, want.mean));
        if (report_due !== want.due)
          report_mismatch($sformatf("report_due got %0b want %0b", report_due, want.due));
      end
    end
  end

  initial begin
    reading_t none;
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = eirm_pkg::CMD_EVENT;
    time_us        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatches     = 0;
    calm_beats     = 0;
    calm_cycles    = 0;
    stall_left     = 0;
    clock_us       = '0;
    none           = '0;
    next_slot      = 0;
    stamp_count    = 0;
    last_report_us = '0;
    period_s       = eirm_pkg::PERIOD_RESET;
    foreach (stamps[k]) stamps[k] = '0;

    // Reset state: empty ring, period of one second, last report at zero.
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd0, 1'b1,
                                eirm_pkg::MEAN_SENTINEL, 1'b0));
    // Exactly one period elapsed is not enough; one microsecond more is.
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd1_000_000, 1'b1,
                                eirm_pkg::MEAN_SENTINEL, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd1_000_001, 1'b1,
                                eirm_pkg::MEAN_SENTINEL, 1'b1));
    // One stamp only: still no interval.
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, 63'd100, 1'b1,
                                eirm_pkg::MEAN_SENTINEL, 1'b0));
    // Backward by one: the wrapped span equals the sentinel value.
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, 63'd99, 1'b1,
                                eirm_pkg::MEAN_SENTINEL, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, 63'd199, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd1_000_002, 1'b0, '0, 1'b0));
    // Time behind the last report wraps to a huge elapsed value.
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd0, 1'b0, '0, 1'b0));
    // Fill the ring, then overwrite the oldest stamps across the time wrap.
    for (int k = 3; k <= 9; k++)
      directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT,
                                  eirm_pkg::TIME_W'(k * 100), 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, T_MAX, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, 63'd5, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, T_MAX, 1'b0, '0, 1'b0));
    // Zero period: any nonzero elapsed time is due.
    directed_rows.push_back(row(ROW_PERIOD, eirm_pkg::CMD_EVENT, 63'd0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, T_MAX, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd0, 1'b0, '0, 1'b0));
    // Largest period, at and just past its boundary.
    directed_rows.push_back(row(ROW_PERIOD, eirm_pkg::CMD_EVENT, 63'd4095, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd4_095_000_000, 1'b0,
                                '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_POLL, 63'd4_095_000_001, 1'b0,
                                '0, 1'b0));
    directed_rows.push_back(row(ROW_BEAT, eirm_pkg::CMD_EVENT, 63'd0, 1'b0, '0, 1'b0));

    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_PERIOD)
        write_period(eirm_pkg::PERIOD_W'(directed_rows[i].value));
      else
        send_beat(directed_rows[i].op, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under its own period; every switch drains the block.
    clock_us = 63'd4_095_000_001;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_period(eirm_pkg::PERIOD_W'($urandom_range(4095, 0)));
        1:       write_period('0);
        2:       write_period({eirm_pkg::PERIOD_W{1'b1}});
        3:       write_period(eirm_pkg::PERIOD_W'(1));
        default: write_period(eirm_pkg::PERIOD_W'($urandom_range(20, 1)));
      endcase
      repeat (BEATS_PER_PHASE) send_random_beat();
    end
    in_valid = 1'b0;

    wait (awaited_readings.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/eirm_pkg.sv
hw/rtl/eirm_div.sv
hw/rtl/event_interval_rate_meter.sv
bench/tb_event_interval_rate_meter.sv
